FILE: design/srgb2lab_pkg.sv
// Types, constants and the gamma table shared by the sRGB to L*a*b* pixel core.
package srgb2lab_pkg;

   localparam int ST_LIN   = 0;
   localparam int ST_PROD  = 1;
   localparam int ST_XYZ   = 2;
   localparam int ST_NUM   = 3;
   localparam int ST_RECIP = 4;
   localparam int ST_LINF  = 5;
   localparam int ST_CBRT  = 6;
   localparam int CBRT_STEPS = 21;
   localparam int ST_LAB   = ST_CBRT + CBRT_STEPS;
   localparam int ST_FMT   = ST_LAB + 1;
   localparam int ST_OUT   = ST_FMT + 1;
   localparam int STAGES   = ST_OUT + 1;

   localparam logic [20:0] THRESH      = 21'd9286;
   localparam logic [20:0] LIN_F_BASE  = 21'd144631;
   localparam logic [27:0] RECIP_29000 = 28'd151656777;
   localparam logic [26:0] RECIP_10    = 27'd107374183;
   localparam logic [15:0] RECIP_100   = 16'd41944;
   localparam logic [14:0] LIGHT_MAX   = 15'd25600;

   localparam logic [19:0] MATRIX [3][3] = '{
      '{20'd455032, 20'd394495, 20'd199049},
      '{20'd223002, 20'd749900, 20'd75674},
      '{20'd18621,  20'd114794, 20'd915161}
   };

   typedef logic [16:0] gamma_arr_type [256];

   typedef struct packed {
      logic [20:0] y;
      logic [41:0] y2;
      logic [60:0] r;
   } croot_type;

   typedef struct packed {
      croot_type [2:0]        lane;
      logic [2:0]             above;
      logic [2:0][20:0]       linf;
      logic [23:0]            linl;
   } cbrt_stage_type;

   function automatic gamma_arr_type gamma_table();
      gamma_arr_type tab;
      logic [63:0]   x;
      logic [63:0]   w;
      logic [63:0]   lo;
      logic [63:0]   hi;
      logic [63:0]   mid;
      logic [63:0]   p;
      for (int c = 0; c < 256; c++) begin
         if (c <= 10) begin
            tab[c] = 17'((64'(c) * 64'd655360 + 64'd16473) / 64'd32946);
         end else begin
            x  = ((64'(c) * 64'd1000 + 64'd14025) << 30) / 64'd269025;
            w  = (x * x) >> 30;
            lo = 64'd0;
            hi = 64'd1 << 30;
            for (int it = 0; it < 32; it++) begin
               if (lo < hi) begin
                  mid = lo + ((hi - lo + 64'd1) >> 1);
                  p   = mid;
                  for (int j = 0; j < 4; j++) begin
                     p = (p * mid) >> 30;
                  end
                  if (p <= w) begin
                     lo = mid;
                  end else begin
                     hi = mid - 64'd1;
                  end
               end
            end
            tab[c] = 17'((((w * lo) >> 30) + 64'd8192) >> 14);
         end
      end
      return tab;
   endfunction

   localparam gamma_arr_type GAMMA_TAB = gamma_table();

   function automatic croot_type croot_step(croot_type c, int k);
      croot_type   n;
      logic [65:0] delta;
      n     = c;
      delta = ((66'(c.y2) * 66'd3) << k) + ((66'(c.y) * 66'd3) << (2 * k))
            + (66'd1 << (3 * k));
      if (delta <= 66'(c.r)) begin
         n.y  = c.y | (21'd1 << k);
         n.y2 = c.y2 + (42'(c.y) << (k + 1)) + (42'd1 << (2 * k));
         n.r  = c.r - 61'(delta);
      end
      return n;
   endfunction

endpackage

FILE: design/srgb_to_cielab_pixel_core.sv
// Pipelined sRGB to CIE L*a*b* (D65) pixel converter.
// One pixel enters per clock unless rsp_ready stalls a full pipeline; the depth is set by the
// 21-stage bit-per-stage cube root that follows the gamma table, matrix and linear-segment
// stages. Each stage holds while it is full and the one after it holds, so bubbles close up
// and a waiting result does not stop input until every stage is occupied. output_format
// selects packed 8-bit or signed fixed point and may only change while the pipeline is empty.
module srgb_to_cielab_pixel_core
   import srgb2lab_pkg::*;
#(
   parameter int FRACTION_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_blue,
   input  logic [7:0]         req_green,
   input  logic [7:0]         req_red,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [14:0]        rsp_lightness,
   output logic signed [15:0] rsp_green_red_axis,
   output logic signed [15:0] rsp_blue_yellow_axis,
   input  logic               csr_write_enable,
   input  logic [0:0]         csr_write_data
);

   localparam int SHIFT = 20 - FRACTION_BITS;
   localparam logic signed [31:0] HALF = 32'sd1 <<< (SHIFT - 1);

   logic                output_format_ff;
   logic [STAGES-1:0]   valid_ff;
   logic [STAGES-1:0]   valid_in;
   logic [STAGES-1:0]   load;

   logic [16:0]         lin_ff [3];
   logic [36:0]         prod_ff [3][3];
   logic [20:0]         xyz_ff [3];
   logic [20:0]         t3_ff [3];
   logic [28:0]         n2_ff [3];
   logic [27:0]         nl_ff;
   logic [20:0]         t4_ff [3];
   logic [28:0]         n24_ff [3];
   logic [56:0]         qp_ff [3];
   logic [27:0]         nl4_ff;
   logic [54:0]         lp_ff;
   logic [20:0]         t5_ff [3];
   logic [20:0]         linf_ff [3];
   logic [23:0]         linl_ff;
   cbrt_stage_type      seed;
   cbrt_stage_type      cb_ff [CBRT_STEPS];
   logic signed [28:0]  l_ff;
   logic signed [30:0]  a_ff;
   logic signed [30:0]  b_ff;
   logic [14:0]         lv_ff;
   logic [7:0]          a8_ff;
   logic [7:0]          b8_ff;
   logic [14:0]         lfx_ff;
   logic signed [15:0]  afx_ff;
   logic signed [15:0]  bfx_ff;
   logic [14:0]         light_ff;
   logic signed [15:0]  gr_ff;
   logic signed [15:0]  by_ff;

   logic [14:0]         q5 [3];
   logic [24:0]         ql5;
   logic [20:0]         fsel [3];
   logic signed [21:0]  dxy;
   logic signed [21:0]  dyz;
   logic [35:0]         l255;
   logic signed [31:0]  a_flr;
   logic signed [31:0]  b_flr;
   logic signed [31:0]  l_fix;
   logic signed [31:0]  a_fix;
   logic signed [31:0]  b_fix;
   logic [30:0]         l_div;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_format_ff <= 1'b0;
      end else if (csr_write_enable) begin
         output_format_ff <= csr_write_data[0];
      end
   end

   always_comb begin
      load[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int i = STAGES - 2; i >= 0; i--) begin
         load[i] = !valid_ff[i] || load[i+1];
      end
      valid_in = {valid_ff[STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int i = 0; i < STAGES; i++) begin
            if (load[i]) begin
               valid_ff[i] <= valid_in[i];
            end
         end
      end
   end

   assign req_ready = load[ST_LIN];

   always_ff @(posedge clock) begin
      if (load[ST_LIN]) begin
         lin_ff[0] <= GAMMA_TAB[req_red];
         lin_ff[1] <= GAMMA_TAB[req_green];
         lin_ff[2] <= GAMMA_TAB[req_blue];
      end
      if (load[ST_PROD]) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[i][j] <= 37'(MATRIX[i][j]) * 37'(lin_ff[j]);
            end
         end
      end
      if (load[ST_XYZ]) begin
         for (int i = 0; i < 3; i++) begin
            xyz_ff[i] <= 21'(((39'(prod_ff[i][0]) + 39'(prod_ff[i][1]) + 39'(prod_ff[i][2])
                         + 39'd32768) >> 16));
         end
      end
      if (load[ST_NUM]) begin
         for (int i = 0; i < 3; i++) begin
            t3_ff[i] <= xyz_ff[i];
            n2_ff[i] <= 29'(29'd22823 * 29'(xyz_ff[i][13:0]) + 29'd5000);
         end
         nl_ff <= 28'(28'd9033 * 28'(xyz_ff[1][13:0]));
      end
      if (load[ST_RECIP]) begin
         for (int i = 0; i < 3; i++) begin
            t4_ff[i]  <= t3_ff[i];
            n24_ff[i] <= n2_ff[i];
            qp_ff[i]  <= 57'(n2_ff[i]) * 57'(RECIP_29000);
         end
         nl4_ff <= nl_ff;
         lp_ff  <= 55'(nl_ff) * 55'(RECIP_10);
      end
      if (load[ST_LINF]) begin
         for (int i = 0; i < 3; i++) begin
            t5_ff[i]   <= t4_ff[i];
            linf_ff[i] <= LIN_F_BASE + 21'(21'd7 * 21'(t4_ff[i][13:0])) + 21'(q5[i]);
         end
         linl_ff <= ql5[23:0];
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         q5[i] = qp_ff[i][56:42];
         if (30'(q5[i]) * 30'd29000 > 30'(n24_ff[i])) begin
            q5[i] = q5[i] - 15'd1;
         end
      end
      ql5 = lp_ff[54:30];
      if (29'(ql5) * 29'd10 > 29'(nl4_ff)) begin
         ql5 = ql5 - 25'd1;
      end
   end

   always_comb begin
      seed = '0;
      for (int i = 0; i < 3; i++) begin
         seed.above[i]  = t5_ff[i] > THRESH;
         seed.linf[i]   = linf_ff[i];
         seed.lane[i].r = {t5_ff[i], 40'd0};
      end
      seed.linl = linl_ff;
   end

   for (genvar j = 0; j < CBRT_STEPS; j++) begin : g_cbrt
      cbrt_stage_type prev;
      cbrt_stage_type nxt;
      if (j == 0) begin : g_first
         assign prev = seed;
      end else begin : g_next
         assign prev = cb_ff[j-1];
      end
      always_comb begin
         nxt = prev;
         for (int i = 0; i < 3; i++) begin
            nxt.lane[i] = croot_step(prev.lane[i], CBRT_STEPS - 1 - j);
         end
      end
      always_ff @(posedge clock) begin
         if (load[ST_CBRT+j]) begin
            cb_ff[j] <= nxt;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         fsel[i] = cb_ff[CBRT_STEPS-1].above[i] ? cb_ff[CBRT_STEPS-1].lane[i].y
                                                 : cb_ff[CBRT_STEPS-1].linf[i];
      end
      dxy = $signed({1'b0, fsel[0]}) - $signed({1'b0, fsel[1]});
      dyz = $signed({1'b0, fsel[1]}) - $signed({1'b0, fsel[2]});
   end

   always_ff @(posedge clock) begin
      if (load[ST_LAB]) begin
         if (cb_ff[CBRT_STEPS-1].above[1]) begin
            l_ff <= $signed(29'(29'd116 * 29'(fsel[1]))) - 29'sd16777216;
         end else begin
            l_ff <= $signed(29'(cb_ff[CBRT_STEPS-1].linl));
         end
         a_ff <= 31'sd500 * 31'(dxy);
         b_ff <= 31'sd200 * 31'(dyz);
      end
   end

   always_comb begin
      l255  = 36'(l_ff[27:0]) * 36'd255;
      a_flr = 32'(a_ff >>> 20) + 32'sd128;
      b_flr = 32'(b_ff >>> 20) + 32'sd128;
      l_fix = (32'(l_ff) + HALF) >>> SHIFT;
      a_fix = (32'(a_ff) + HALF) >>> SHIFT;
      b_fix = (32'(b_ff) + HALF) >>> SHIFT;
   end

   always_ff @(posedge clock) begin
      if (load[ST_FMT]) begin
         lv_ff  <= l_ff[28] ? 15'd0 : l255[34:20];
         a8_ff  <= a_flr < 0 ? 8'd0 : (a_flr > 32'sd255 ? 8'd255 : a_flr[7:0]);
         b8_ff  <= b_flr < 0 ? 8'd0 : (b_flr > 32'sd255 ? 8'd255 : b_flr[7:0]);
         lfx_ff <= l_fix < 0 ? 15'd0 : (l_fix > 32'sd32767 ? 15'd32767 : l_fix[14:0]);
         afx_ff <= a_fix < -32'sd32768 ? -16'sd32768
                 : (a_fix > 32'sd32767 ? 16'sd32767 : a_fix[15:0]);
         bfx_ff <= b_fix < -32'sd32768 ? -16'sd32768
                 : (b_fix > 32'sd32767 ? 16'sd32767 : b_fix[15:0]);
      end
   end

   assign l_div = 31'(lv_ff) * 31'(RECIP_100);

   always_ff @(posedge clock) begin
      if (load[ST_OUT]) begin
         if (output_format_ff) begin
            light_ff <= lfx_ff;
            gr_ff    <= afx_ff;
            by_ff    <= bfx_ff;
         end else begin
            light_ff <= (l_div[30:22] > 9'd255) ? 15'd255 : 15'(l_div[30:22]);
            gr_ff    <= $signed({8'd0, a8_ff});
            by_ff    <= $signed({8'd0, b8_ff});
         end
      end
   end

   assign rsp_valid            = valid_ff[ST_OUT];
   assign rsp_lightness        = light_ff;
   assign rsp_green_red_axis   = gr_ff;
   assign rsp_blue_yellow_axis = by_ff;

   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      !valid_ff[ST_OUT] |-> req_ready)
      else $error("input stalled with an empty output stage");

   a_stage_holds : assert property (@(posedge clock) disable iff (reset)
      (valid_ff[ST_LIN] && !load[ST_PROD]) |=> valid_ff[ST_LIN])
      else $error("first stage item dropped while stalled");

   a_lightness_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lightness <= LIGHT_MAX)
      else $error("lightness beyond full scale");

endmodule
